// File: sv/sphere_cone_visibility_cull_defines.svh
// ---------------------------------------------------------------------------
// Sphere cone visibility cull - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SPHERE_CONE_VISIBILITY_CULL_DEFINES_SVH
`define SPHERE_CONE_VISIBILITY_CULL_DEFINES_SVH

// same-cycle implication
`define SCVC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCVC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/scvc_pkg.sv
// ---------------------------------------------------------------------------
// Sphere cone visibility cull - package
// Field widths, register indexes, result codes and reset values.
// ---------------------------------------------------------------------------
package scvc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int RAD_W   = 32;
    localparam int SCALE_W = 31;
    localparam int DIR_W   = 18;
    localparam int ICS_W   = 31;
    localparam int COS_W   = 17;
    localparam int CFG_MIN_W = 32;
    localparam int IDX_W   = 3;

    // apex offset
    localparam int PROD_W    = RAD_W - 1 + ICS_W;
    localparam int OFF_W     = 46;
    localparam int OFF_SPLIT = 23;
    localparam int PP_W      = DIR_W + OFF_SPLIT + 1;
    localparam int DPROD_W   = DIR_W + OFF_W + 1;
    localparam logic [OFF_W-1:0] OFF_MAX = '1;

    // normalized to vector
    localparam int NORM_BITS = 31;
    localparam int TN_W      = 32;
    localparam logic [TN_W-1:0] TN_MAG_MAX = TN_W'(64'd1 << NORM_BITS);

    // cone compare
    localparam int DP_W       = DIR_W + TN_W;
    localparam int DOT_W      = DP_W + 2;
    localparam int SQI_W      = 2 * TN_W;
    localparam int SQ_W       = 64;
    localparam int DMAG_W     = 50;
    localparam int DHALF_W    = DMAG_W / 2;
    localparam int COS2_W     = 2 * COS_W;
    localparam int SQ_CHUNK_W = 22;
    localparam int RP_W       = COS2_W + SQ_CHUNK_W;
    localparam int LHS_W      = 2 * DMAG_W;

    localparam logic signed [DIR_W-1:0] DIR_Z_RESET = -(DIR_W'(1) << FRAC_BITS_DEF);
    localparam logic [ICS_W-1:0] ICS_RESET = ICS_W'(1) << FRAC_BITS_DEF;

    typedef enum logic [IDX_W-1:0] {
        REG_CAMERA_X   = 3'd0,
        REG_CAMERA_Y   = 3'd1,
        REG_CAMERA_Z   = 3'd2,
        REG_VIEW_DIR_X = 3'd3,
        REG_VIEW_DIR_Y = 3'd4,
        REG_VIEW_DIR_Z = 3'd5,
        REG_INV_SINE   = 3'd6,
        REG_CONE_COS   = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_SIZE = 2'd1,
        CAUSE_CONE = 2'd2
    } cause_t;

endpackage

// File: sv/scvc_offset.sv
// ---------------------------------------------------------------------------
// Sphere cone visibility cull - apex offset stages
// Size check, radius times inverse cone sine, per-axis apex shift product
// and centre minus camera difference. Three register stages.
// ---------------------------------------------------------------------------
module scvc_offset #(
    parameter int COORD_WIDTH = scvc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = scvc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [COORD_WIDTH-1:0]          center [3],
    input  logic signed [scvc_pkg::RAD_W-1:0]      sphere_radius,
    input  logic [scvc_pkg::SCALE_W-1:0]           axis_scale,
    input  logic signed [COORD_WIDTH-1:0]          camera [3],
    input  logic signed [scvc_pkg::DIR_W-1:0]      view_dir [3],
    input  logic [scvc_pkg::ICS_W-1:0]             inverse_cone_sine,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [COORD_WIDTH:0]            diff [3],
    output logic signed [scvc_pkg::DPROD_W-1:0]    dprod [3],
    output logic                                   size_fail
);

    localparam int DIFF_W = COORD_WIDTH + 1;

    logic st1_valid_reg, st2_valid_reg, st3_valid_reg;
    logic en1, en2, en3;

    logic [scvc_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic signed [DIFF_W-1:0]           diff1_reg [3];
    logic signed [DIFF_W-1:0]           diff2_reg [3];
    logic signed [DIFF_W-1:0]           diff3_reg [3];
    logic signed [DIFF_W-1:0]           diff_next [3];
    logic                               fail1_reg, fail2_reg, fail3_reg, fail_next;

    logic [scvc_pkg::PROD_W-1:0]        prod_shr;
    logic [scvc_pkg::OFF_W-1:0]         off;
    logic signed [scvc_pkg::PP_W-1:0]   pp_hi_reg [3];
    logic signed [scvc_pkg::PP_W-1:0]   pp_lo_reg [3];
    logic signed [scvc_pkg::PP_W-1:0]   pp_hi_next [3];
    logic signed [scvc_pkg::PP_W-1:0]   pp_lo_next [3];
    logic signed [scvc_pkg::DPROD_W-1:0] dprod_reg [3];
    logic signed [scvc_pkg::DPROD_W-1:0] dprod_next [3];

    assign en3      = !st3_valid_reg || !out_stall;
    assign en2      = !st2_valid_reg || en3;
    assign en1      = !st1_valid_reg || en2;
    assign in_stall = !en1;

    always_comb
    begin
        fail_next = sphere_radius[scvc_pkg::RAD_W-1] || (sphere_radius == '0)
                    || (axis_scale == '0);
        prod_next = scvc_pkg::PROD_W'(sphere_radius[scvc_pkg::RAD_W-2:0])
                    * scvc_pkg::PROD_W'(inverse_cone_sine);
        for (int i = 0; i < 3; i++)
        begin
            diff_next[i] = DIFF_W'(center[i]) - DIFF_W'(camera[i]);
        end
    end

    always_comb
    begin
        prod_shr = prod_reg >> FRAC_BITS;
        if (prod_shr > scvc_pkg::PROD_W'(scvc_pkg::OFF_MAX))
        begin
            off = scvc_pkg::OFF_MAX;
        end
        else
        begin
            off = prod_shr[scvc_pkg::OFF_W-1:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            pp_lo_next[i] = view_dir[i] * $signed({1'b0, off[scvc_pkg::OFF_SPLIT-1:0]});
            pp_hi_next[i] = view_dir[i]
                            * $signed({1'b0, off[scvc_pkg::OFF_W-1:scvc_pkg::OFF_SPLIT]});
            dprod_next[i] = (scvc_pkg::DPROD_W'(pp_hi_reg[i]) <<< scvc_pkg::OFF_SPLIT)
                            + scvc_pkg::DPROD_W'(pp_lo_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                st1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (en3)
            begin
                st3_valid_reg <= st2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg  <= prod_next;
            fail1_reg <= fail_next;
            diff1_reg <= diff_next;
        end
        if (en2)
        begin
            pp_hi_reg <= pp_hi_next;
            pp_lo_reg <= pp_lo_next;
            fail2_reg <= fail1_reg;
            diff2_reg <= diff1_reg;
        end
        if (en3)
        begin
            dprod_reg <= dprod_next;
            fail3_reg <= fail2_reg;
            diff3_reg <= diff2_reg;
        end
    end

    assign out_valid = st3_valid_reg;
    assign diff      = diff3_reg;
    assign dprod     = dprod_reg;
    assign size_fail = fail3_reg;

endmodule

// File: sv/scvc_norm.sv
// ---------------------------------------------------------------------------
// Sphere cone visibility cull - to vector and normalization stages
// Forms centre minus apex, finds the common right shift that brings every
// magnitude to at most 2^31, and applies it. Three register stages.
// ---------------------------------------------------------------------------
`include "sphere_cone_visibility_cull_defines.svh"

module scvc_norm #(
    parameter int COORD_WIDTH = scvc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = scvc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [COORD_WIDTH:0]            diff [3],
    input  logic signed [scvc_pkg::DPROD_W-1:0]    dprod [3],
    input  logic                                   size_fail,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [scvc_pkg::TN_W-1:0]       tn [3],
    output logic [scvc_pkg::TN_W-1:0]              tm [3],
    output logic                                   out_fail
);

    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int SCALED_W = scvc_pkg::DPROD_W - FRAC_BITS;
    localparam int T_W      = ((DIFF_W > SCALED_W) ? DIFF_W : SCALED_W) + 1;
    localparam int K_W      = $clog2(T_W - scvc_pkg::NORM_BITS + 1);

    logic st1_valid_reg, st2_valid_reg, st3_valid_reg;
    logic en1, en2, en3;
    logic fail1_reg, fail2_reg, fail3_reg;

    logic signed [scvc_pkg::DPROD_W-1:0] scaled [3];
    logic signed [T_W-1:0]   t_next [3];
    logic signed [T_W-1:0]   t1_reg [3];
    logic signed [T_W-1:0]   t2_reg [3];
    logic [T_W-1:0]          mag [3];
    logic [T_W-1:0]          mag_or;
    logic [K_W-1:0]          k_reg, k_next;
    logic signed [T_W-1:0]   t_shr [3];
    logic [scvc_pkg::TN_W-1:0] tn_next [3];
    logic [scvc_pkg::TN_W-1:0] tm_next [3];
    logic signed [scvc_pkg::TN_W-1:0] tn_reg [3];
    logic [scvc_pkg::TN_W-1:0] tm_reg [3];

    assign en3      = !st3_valid_reg || !out_stall;
    assign en2      = !st2_valid_reg || en3;
    assign en1      = !st1_valid_reg || en2;
    assign in_stall = !en1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scaled[i] = dprod[i] >>> FRAC_BITS;
            t_next[i] = T_W'(diff[i]) + T_W'(scaled[i]);
        end
    end

    // shift = bits of the widest magnitude above bit 30
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = t1_reg[i][T_W-1] ? (~t1_reg[i] + 1'b1) : t1_reg[i];
        end
        mag_or = mag[0] | mag[1] | mag[2];
        k_next = '0;
        for (int b = scvc_pkg::NORM_BITS; b < T_W; b++)
        begin
            if (mag_or[b])
            begin
                k_next = K_W'(b - scvc_pkg::NORM_BITS + 1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t_shr[i]   = t2_reg[i] >>> k_reg;
            tn_next[i] = t_shr[i][scvc_pkg::TN_W-1:0];
            tm_next[i] = tn_next[i][scvc_pkg::TN_W-1] ? (~tn_next[i] + 1'b1) : tn_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                st1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (en3)
            begin
                st3_valid_reg <= st2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            t1_reg    <= t_next;
            fail1_reg <= size_fail;
        end
        if (en2)
        begin
            t2_reg    <= t1_reg;
            k_reg     <= k_next;
            fail2_reg <= fail1_reg;
        end
        if (en3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tn_reg[i] <= tn_next[i];
            end
            tm_reg    <= tm_next;
            fail3_reg <= fail2_reg;
        end
    end

    assign out_valid = st3_valid_reg;
    assign tn        = tn_reg;
    assign tm        = tm_reg;
    assign out_fail  = fail3_reg;

    `SCVC_ASSERT_IMP(a_norm_bound, st3_valid_reg, (tm_reg[0] <= scvc_pkg::TN_MAG_MAX) && (tm_reg[1] <= scvc_pkg::TN_MAG_MAX) && (tm_reg[2] <= scvc_pkg::TN_MAG_MAX), "normalized magnitude above 2^31")
    `SCVC_ASSERT_NXT(a_norm_hold, st2_valid_reg && !en3, st3_valid_reg && $stable(tm_reg[0]), "stalled normalized word changed")

endmodule

// File: sv/scvc_cone.sv
// ---------------------------------------------------------------------------
// Sphere cone visibility cull - cone compare stages
// dot(dir,to) and |to|^2, then dot^2 against cos^2 * |to|^2 through split
// partial products. Five register stages, the last is the result register.
// ---------------------------------------------------------------------------
`include "sphere_cone_visibility_cull_defines.svh"

module scvc_cone (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [scvc_pkg::TN_W-1:0]    tn [3],
    input  logic [scvc_pkg::TN_W-1:0]           tm [3],
    input  logic                                size_fail,
    input  logic signed [scvc_pkg::DIR_W-1:0]   view_dir [3],
    input  logic [scvc_pkg::COS_W-1:0]          cone_cosine,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                visible,
    output scvc_pkg::cause_t                    reject_cause
);

    logic st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg, st5_valid_reg;
    logic en1, en2, en3, en4, en5;
    logic fail1_reg, fail2_reg, fail3_reg, fail4_reg;

    logic [scvc_pkg::COS2_W-1:0]        cos2_reg;
    logic signed [scvc_pkg::DP_W-1:0]   dp_reg [3];
    logic signed [scvc_pkg::DP_W-1:0]   dp_next [3];
    logic [scvc_pkg::SQI_W-1:0]         sqi_reg [3];
    logic [scvc_pkg::SQI_W-1:0]         sqi_next [3];
    logic signed [scvc_pkg::DOT_W-1:0]  dot_reg, dot_next;
    logic [scvc_pkg::SQ_W-1:0]          sq_reg, sq_next;

    logic                               pos3_reg, pos4_reg, pos_next;
    logic [scvc_pkg::DMAG_W-1:0]        dmag;
    logic [scvc_pkg::DHALF_W-1:0]       dh, dl;
    logic [scvc_pkg::DMAG_W-1:0]        hh_reg, hl_reg, ll_reg;
    logic [scvc_pkg::DMAG_W-1:0]        hh_next, hl_next, ll_next;
    logic [scvc_pkg::SQ_CHUNK_W-1:0]    chunk [3];
    logic [scvc_pkg::RP_W-1:0]          rp_reg [3];
    logic [scvc_pkg::RP_W-1:0]          rp_next [3];
    logic [scvc_pkg::LHS_W-1:0]         lhs_reg, lhs_next, rhs_reg, rhs_next;

    logic                               visible_reg, visible_next;
    scvc_pkg::cause_t                   cause_reg, cause_next;

    assign en5      = !st5_valid_reg || !out_stall;
    assign en4      = !st4_valid_reg || en5;
    assign en3      = !st3_valid_reg || en4;
    assign en2      = !st2_valid_reg || en3;
    assign en1      = !st1_valid_reg || en2;
    assign in_stall = !en1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp_next[i]  = view_dir[i] * tn[i];
            sqi_next[i] = tm[i] * tm[i];
        end
        dot_next = scvc_pkg::DOT_W'(dp_reg[0]) + scvc_pkg::DOT_W'(dp_reg[1])
                   + scvc_pkg::DOT_W'(dp_reg[2]);
        sq_next  = scvc_pkg::SQ_W'(sqi_reg[0]) + scvc_pkg::SQ_W'(sqi_reg[1])
                   + scvc_pkg::SQ_W'(sqi_reg[2]);
    end

    // dot^2 as three half-width products, |to|^2 * cos^2 as three chunks
    always_comb
    begin
        pos_next = !dot_reg[scvc_pkg::DOT_W-1] && (dot_reg != '0);
        dmag     = dot_reg[scvc_pkg::DMAG_W-1:0];
        dh       = dmag[scvc_pkg::DMAG_W-1:scvc_pkg::DHALF_W];
        dl       = dmag[scvc_pkg::DHALF_W-1:0];
        hh_next  = dh * dh;
        hl_next  = dh * dl;
        ll_next  = dl * dl;
        chunk[0] = sq_reg[scvc_pkg::SQ_CHUNK_W-1:0];
        chunk[1] = sq_reg[2*scvc_pkg::SQ_CHUNK_W-1:scvc_pkg::SQ_CHUNK_W];
        chunk[2] = scvc_pkg::SQ_CHUNK_W'(sq_reg[scvc_pkg::SQ_W-1:2*scvc_pkg::SQ_CHUNK_W]);
        for (int i = 0; i < 3; i++)
        begin
            rp_next[i] = cos2_reg * chunk[i];
        end
    end

    always_comb
    begin
        lhs_next = (scvc_pkg::LHS_W'(hh_reg) << (2 * scvc_pkg::DHALF_W))
                   + (scvc_pkg::LHS_W'(hl_reg) << (scvc_pkg::DHALF_W + 1))
                   + scvc_pkg::LHS_W'(ll_reg);
        rhs_next = (scvc_pkg::LHS_W'(rp_reg[2]) << (2 * scvc_pkg::SQ_CHUNK_W))
                   + (scvc_pkg::LHS_W'(rp_reg[1]) << scvc_pkg::SQ_CHUNK_W)
                   + scvc_pkg::LHS_W'(rp_reg[0]);
    end

    always_comb
    begin
        priority if (fail4_reg)
        begin
            visible_next = 1'b0;
            cause_next   = scvc_pkg::CAUSE_SIZE;
        end
        else if (pos4_reg && (lhs_reg > rhs_reg))
        begin
            visible_next = 1'b1;
            cause_next   = scvc_pkg::CAUSE_NONE;
        end
        else
        begin
            visible_next = 1'b0;
            cause_next   = scvc_pkg::CAUSE_CONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                st1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (en3)
            begin
                st3_valid_reg <= st2_valid_reg;
            end
            if (en4)
            begin
                st4_valid_reg <= st3_valid_reg;
            end
            if (en5)
            begin
                st5_valid_reg <= st4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cos2_reg <= cone_cosine * cone_cosine;
        if (en1)
        begin
            dp_reg    <= dp_next;
            sqi_reg   <= sqi_next;
            fail1_reg <= size_fail;
        end
        if (en2)
        begin
            dot_reg   <= dot_next;
            sq_reg    <= sq_next;
            fail2_reg <= fail1_reg;
        end
        if (en3)
        begin
            pos3_reg  <= pos_next;
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            ll_reg    <= ll_next;
            rp_reg    <= rp_next;
            fail3_reg <= fail2_reg;
        end
        if (en4)
        begin
            pos4_reg  <= pos3_reg;
            lhs_reg   <= lhs_next;
            rhs_reg   <= rhs_next;
            fail4_reg <= fail3_reg;
        end
        if (en5)
        begin
            visible_reg <= visible_next;
            cause_reg   <= cause_next;
        end
    end

    assign out_valid    = st5_valid_reg;
    assign visible      = visible_reg;
    assign reject_cause = cause_reg;

    `SCVC_ASSERT_NXT(a_cone_nonpos, st4_valid_reg && en5 && !pos4_reg, !visible_reg, "non-positive dot marked visible")
    `SCVC_ASSERT_NXT(a_cone_size, st4_valid_reg && en5 && fail4_reg, cause_reg == scvc_pkg::CAUSE_SIZE, "size reject lost its cause")

endmodule

// File: sv/sphere_cone_visibility_cull.sv
// ---------------------------------------------------------------------------
// Sphere cone visibility cull - top level
// Bounding sphere against view cone test, one sphere per clock when the output
// is not stalled, with the configuration register file.
// ---------------------------------------------------------------------------
// Takes one sphere word per clock when the output is not stalled and returns
// one result word for each, in order, through three apex offset stages, three
// normalization stages and five cone compare stages, the last being the
// result register. The stage split follows the 31x31 offset product, the
// 18x46 apex shift split in two, and the 50-bit dot square split into
// half-width products. Every stage holds its word under stall and a stage
// with no word keeps loading, so empty slots close up and input is taken
// while a finished result waits. Write the configuration registers only while
// no sphere is in flight.
module sphere_cone_visibility_cull #(
    parameter int COORD_WIDTH = scvc_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = scvc_pkg::FRAC_BITS_DEF,
    localparam int CFG_W = (COORD_WIDTH > scvc_pkg::CFG_MIN_W) ? COORD_WIDTH
                                                              : scvc_pkg::CFG_MIN_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_WIDTH-1:0]      center_x,
    input  logic signed [COORD_WIDTH-1:0]      center_y,
    input  logic signed [COORD_WIDTH-1:0]      center_z,
    input  logic signed [scvc_pkg::RAD_W-1:0]  sphere_radius,
    input  logic [scvc_pkg::SCALE_W-1:0]       axis_scale,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               visible,
    output logic [1:0]                         reject_cause,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [scvc_pkg::IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data
);

    logic signed [COORD_WIDTH-1:0]          camera_reg [3];
    logic signed [scvc_pkg::DIR_W-1:0]      view_dir_reg [3];
    logic [scvc_pkg::ICS_W-1:0]             ics_reg;
    logic [scvc_pkg::COS_W-1:0]             cos_reg;
    logic signed [COORD_WIDTH-1:0]          center [3];

    logic                                   off_valid, off_stall, off_fail;
    logic signed [COORD_WIDTH:0]            off_diff [3];
    logic signed [scvc_pkg::DPROD_W-1:0]    off_dprod [3];
    logic                                   norm_valid, norm_stall, norm_fail;
    logic signed [scvc_pkg::TN_W-1:0]       norm_tn [3];
    logic [scvc_pkg::TN_W-1:0]              norm_tm [3];
    scvc_pkg::cause_t                       cause;

    assign cfg_ready = 1'b1;
    assign center[0] = center_x;
    assign center[1] = center_y;
    assign center[2] = center_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_reg[0]   <= '0;
            camera_reg[1]   <= '0;
            camera_reg[2]   <= '0;
            view_dir_reg[0] <= '0;
            view_dir_reg[1] <= '0;
            view_dir_reg[2] <= scvc_pkg::DIR_Z_RESET;
            ics_reg         <= scvc_pkg::ICS_RESET;
            cos_reg         <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (scvc_pkg::reg_index_t'(cfg_index))
                scvc_pkg::REG_CAMERA_X:   camera_reg[0]   <= cfg_data[COORD_WIDTH-1:0];
                scvc_pkg::REG_CAMERA_Y:   camera_reg[1]   <= cfg_data[COORD_WIDTH-1:0];
                scvc_pkg::REG_CAMERA_Z:   camera_reg[2]   <= cfg_data[COORD_WIDTH-1:0];
                scvc_pkg::REG_VIEW_DIR_X: view_dir_reg[0] <= cfg_data[scvc_pkg::DIR_W-1:0];
                scvc_pkg::REG_VIEW_DIR_Y: view_dir_reg[1] <= cfg_data[scvc_pkg::DIR_W-1:0];
                scvc_pkg::REG_VIEW_DIR_Z: view_dir_reg[2] <= cfg_data[scvc_pkg::DIR_W-1:0];
                scvc_pkg::REG_INV_SINE:   ics_reg         <= cfg_data[scvc_pkg::ICS_W-1:0];
                scvc_pkg::REG_CONE_COS:   cos_reg         <= cfg_data[scvc_pkg::COS_W-1:0];
            endcase
        end
    end

    scvc_offset #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_offset (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .center            (center),
        .sphere_radius     (sphere_radius),
        .axis_scale        (axis_scale),
        .camera            (camera_reg),
        .view_dir          (view_dir_reg),
        .inverse_cone_sine (ics_reg),
        .out_valid         (off_valid),
        .out_stall         (off_stall),
        .diff              (off_diff),
        .dprod             (off_dprod),
        .size_fail         (off_fail)
    );

    scvc_norm #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (off_valid),
        .in_stall  (off_stall),
        .diff      (off_diff),
        .dprod     (off_dprod),
        .size_fail (off_fail),
        .out_valid (norm_valid),
        .out_stall (norm_stall),
        .tn        (norm_tn),
        .tm        (norm_tm),
        .out_fail  (norm_fail)
    );

    scvc_cone u_cone (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (norm_valid),
        .in_stall     (norm_stall),
        .tn           (norm_tn),
        .tm           (norm_tm),
        .size_fail    (norm_fail),
        .view_dir     (view_dir_reg),
        .cone_cosine  (cos_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .visible      (visible),
        .reject_cause (cause)
    );

    assign reject_cause = cause;

    `SCVC_ASSERT_IMP(a_top_flow, !out_stall, !in_stall, "input stalled while output drains")
    `SCVC_ASSERT_IMP(a_top_code, out_valid, visible == (cause == scvc_pkg::CAUSE_NONE), "visible flag and reject cause disagree")

endmodule
